### rtl/rgp_pkg.sv
// Shared types, constants and register map of the RGB565 gradient pixel block.
// Used by every module under rtl; depends on nothing.
`default_nettype none
package rgp_pkg;

  localparam int IDX_W   = 10;   // pixel index width
  localparam int CNT_W   = 11;   // pixel count width
  localparam int CH_W    = 6;    // widest colour channel (green)
  localparam int RB_W    = 5;    // red and blue channel width
  localparam int NUM_CH  = 3;
  localparam int QUO_W   = 6;    // quotient magnitude is below 64
  localparam int REM_W   = 16;   // index times delta magnitude, at most 64449
  localparam int BYTE_W  = 8;

  localparam logic [CNT_W-1:0] MAX_PIXELS = 11'd1024;

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_START_RED   = 3'd0;
  localparam logic [2:0] REG_START_GREEN = 3'd1;
  localparam logic [2:0] REG_START_BLUE  = 3'd2;
  localparam logic [2:0] REG_END_RED     = 3'd3;
  localparam logic [2:0] REG_END_GREEN   = 3'd4;
  localparam logic [2:0] REG_END_BLUE    = 3'd5;
  localparam logic [2:0] REG_PIXEL_COUNT = 3'd6;

  typedef struct packed {
    logic [RB_W-1:0]  start_red;
    logic [CH_W-1:0]  start_green;
    logic [RB_W-1:0]  start_blue;
    logic [RB_W-1:0]  end_red;
    logic [CH_W-1:0]  end_green;
    logic [RB_W-1:0]  end_blue;
    logic [CNT_W-1:0] pixel_count;
  } cfg_t;

  // Data handed from cell to cell along the division chain.
  typedef struct packed {
    logic                           oor;
    logic [CNT_W-1:0]               cnt;
    logic [NUM_CH-1:0]              neg;
    logic [NUM_CH-1:0][REM_W-1:0]   rem;
    logic [NUM_CH-1:0][QUO_W-1:0]   quo;
  } div_data_t;

endpackage
`default_nettype wire

### rtl/rgb565_gradient_pixel.sv
// RGB565 gradient pixel generator, top level.
// Depends on rgp_pkg, rgp_cfg_regs, rgp_front and rgp_div_cell.
//
// Usage: program the start colour, end colour and pixel count over the APB
// port while no pixel is in flight. Each transfer on the in_ stream carries a
// pixel index; each transfer on the out_ stream carries that gradient pixel
// as two RGB565 bytes (high byte in tdata bits 7:0, low byte in 15:8) and an
// out-of-range flag in tuser, in which case both bytes are zero.
// An input transfer reaches out_tvalid through the entry register, which
// takes the index at the transfer edge, then a chain of six division cells
// (one quotient bit each) and the output register. Throughput is one pixel
// per cycle unless the output stalls; the pipeline holds up to eight pixels in flight.
// When the receiver stalls with a result waiting, the whole chain holds and
// in_tready drops in the same cycle; it rises again once the result is taken.
// Reset clears all valid flags and loads the register reset values: start
// black, end white, 1024 pixels.
`default_nettype none
module rgb565_gradient_pixel (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // in_tdata: [9:0] pixel_index, [15:10] zero
  input  wire logic [15:0]                in_tdata,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // out_tdata: [7:0] pixel_high_byte, [15:8] pixel_low_byte
  output logic [15:0]                     out_tdata,
  // out_tuser: [0] index_out_of_range
  output logic                            out_tuser,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [rgp_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [rgp_pkg::DATA_W-1:0] cfg_pwdata,
  output logic      [rgp_pkg::DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  localparam int NUM_CELLS = rgp_pkg::QUO_W;

  rgp_pkg::cfg_t                          cfg;
  logic                                   en;
  logic [NUM_CELLS:0]                     stage_valid;
  rgp_pkg::div_data_t                     stage_data [NUM_CELLS+1];
  rgp_pkg::div_data_t                     last;

  logic [rgp_pkg::NUM_CH-1:0][rgp_pkg::CH_W-1:0] start_ch;
  logic [rgp_pkg::NUM_CH-1:0][rgp_pkg::CH_W-1:0] chan;
  logic [rgp_pkg::NUM_CH-1:0][rgp_pkg::CH_W:0]   step;
  logic [rgp_pkg::BYTE_W-1:0]             high_byte, low_byte;

  logic                                   out_valid_r, out_valid_nxt;
  logic [15:0]                            out_data_r, out_data_nxt;
  logic                                   out_oor_r, out_oor_nxt;

  assign cfg_pready = 1'b1;

  rgp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // The chain advances whenever the output register is free or being emptied.
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  rgp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_tvalid),
    .pixel_index (in_tdata[rgp_pkg::IDX_W-1:0]),
    .cfg         (cfg),
    .out_valid   (stage_valid[0]),
    .out_data    (stage_data[0])
  );

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    rgp_div_cell #(
      .SHIFT (NUM_CELLS - 1 - k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (stage_valid[k]),
      .in_data   (stage_data[k]),
      .out_valid (stage_valid[k+1]),
      .out_data  (stage_data[k+1])
    );
  end

  assign last = stage_data[NUM_CELLS];

  assign start_ch[rgp_pkg::CH_RED]   = rgp_pkg::CH_W'(cfg.start_red);
  assign start_ch[rgp_pkg::CH_GREEN] = cfg.start_green;
  assign start_ch[rgp_pkg::CH_BLUE]  = rgp_pkg::CH_W'(cfg.start_blue);

  // Apply the sign to the truncated quotient and add it to the start value.
  always_comb begin
    for (int c = 0; c < rgp_pkg::NUM_CH; c++) begin
      step[c] = last.neg[c] ? -{1'b0, last.quo[c]} : {1'b0, last.quo[c]};
      chan[c] = start_ch[c] + step[c][rgp_pkg::CH_W-1:0];
    end
    high_byte = {chan[rgp_pkg::CH_RED][rgp_pkg::RB_W-1:0],
                 chan[rgp_pkg::CH_GREEN][5:3]};
    low_byte  = {chan[rgp_pkg::CH_GREEN][2:0],
                 chan[rgp_pkg::CH_BLUE][rgp_pkg::RB_W-1:0]};
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_oor_nxt   = out_oor_r;
    if (en) begin
      out_valid_nxt = stage_valid[NUM_CELLS];
      out_oor_nxt   = last.oor;
      out_data_nxt  = last.oor ? '0 : {low_byte, high_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_oor_r  <= out_oor_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_oor_r;

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_oor_r |-> out_data_r == '0)
    else $error("out-of-range result carries non-zero bytes");

  a_ready_follows_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_valid_r || out_tready))
    else $error("input ready does not follow the output stall");

  a_stall_holds_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> $stable(stage_valid))
    else $error("division chain moved during an output stall");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && stage_valid == '0)
    else $error("valid flags not cleared by reset");

endmodule
`default_nettype wire

### rtl/rgp_cfg_regs.sv
// Configuration register file of the gradient block, written and read over APB.
// Depends on rgp_pkg.
`default_nettype none
module rgp_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rgp_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [rgp_pkg::DATA_W-1:0]  pwdata,
  output logic      [rgp_pkg::DATA_W-1:0]  prdata,
  output rgp_pkg::cfg_t                    cfg
);

  rgp_pkg::cfg_t cfg_r, cfg_nxt;
  logic [2:0]    reg_idx;
  logic          wr_en;

  assign reg_idx = paddr[rgp_pkg::ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        rgp_pkg::REG_START_RED:   cfg_nxt.start_red   = pwdata[rgp_pkg::RB_W-1:0];
        rgp_pkg::REG_START_GREEN: cfg_nxt.start_green = pwdata[rgp_pkg::CH_W-1:0];
        rgp_pkg::REG_START_BLUE:  cfg_nxt.start_blue  = pwdata[rgp_pkg::RB_W-1:0];
        rgp_pkg::REG_END_RED:     cfg_nxt.end_red     = pwdata[rgp_pkg::RB_W-1:0];
        rgp_pkg::REG_END_GREEN:   cfg_nxt.end_green   = pwdata[rgp_pkg::CH_W-1:0];
        rgp_pkg::REG_END_BLUE:    cfg_nxt.end_blue    = pwdata[rgp_pkg::RB_W-1:0];
        rgp_pkg::REG_PIXEL_COUNT: cfg_nxt.pixel_count = pwdata[rgp_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_red   <= '0;
      cfg_r.start_green <= '0;
      cfg_r.start_blue  <= '0;
      cfg_r.end_red     <= '1;
      cfg_r.end_green   <= '1;
      cfg_r.end_blue    <= '1;
      cfg_r.pixel_count <= rgp_pkg::MAX_PIXELS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      rgp_pkg::REG_START_RED:   prdata = rgp_pkg::DATA_W'(cfg_r.start_red);
      rgp_pkg::REG_START_GREEN: prdata = rgp_pkg::DATA_W'(cfg_r.start_green);
      rgp_pkg::REG_START_BLUE:  prdata = rgp_pkg::DATA_W'(cfg_r.start_blue);
      rgp_pkg::REG_END_RED:     prdata = rgp_pkg::DATA_W'(cfg_r.end_red);
      rgp_pkg::REG_END_GREEN:   prdata = rgp_pkg::DATA_W'(cfg_r.end_green);
      rgp_pkg::REG_END_BLUE:    prdata = rgp_pkg::DATA_W'(cfg_r.end_blue);
      rgp_pkg::REG_PIXEL_COUNT: prdata = rgp_pkg::DATA_W'(cfg_r.pixel_count);
      default:                  prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

### rtl/rgp_front.sv
// Entry stage: saturates the count, flags out-of-range indices and forms the
// per-channel dividend |index * (end - start)| with its sign. Depends on rgp_pkg.
`default_nettype none
module rgp_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire logic [rgp_pkg::IDX_W-1:0]  pixel_index,
  input  wire rgp_pkg::cfg_t              cfg,
  output logic                            out_valid,
  output rgp_pkg::div_data_t              out_data
);

  logic                                               valid_r;
  rgp_pkg::div_data_t                                 data_r, data_nxt;
  logic [rgp_pkg::CNT_W-1:0]                          cnt_eff;
  logic [rgp_pkg::NUM_CH-1:0][rgp_pkg::CH_W-1:0]      from_ch, to_ch;
  logic [rgp_pkg::NUM_CH-1:0][rgp_pkg::CH_W:0]        delta;
  logic [rgp_pkg::NUM_CH-1:0][rgp_pkg::CH_W-1:0]      mag;

  assign from_ch[rgp_pkg::CH_RED]   = rgp_pkg::CH_W'(cfg.start_red);
  assign from_ch[rgp_pkg::CH_GREEN] = cfg.start_green;
  assign from_ch[rgp_pkg::CH_BLUE]  = rgp_pkg::CH_W'(cfg.start_blue);
  assign to_ch[rgp_pkg::CH_RED]     = rgp_pkg::CH_W'(cfg.end_red);
  assign to_ch[rgp_pkg::CH_GREEN]   = cfg.end_green;
  assign to_ch[rgp_pkg::CH_BLUE]    = rgp_pkg::CH_W'(cfg.end_blue);

  assign cnt_eff = (cfg.pixel_count > rgp_pkg::MAX_PIXELS) ? rgp_pkg::MAX_PIXELS
                                                           : cfg.pixel_count;

  always_comb begin
    data_nxt.cnt = cnt_eff;
    // A count of zero makes every index out of range.
    data_nxt.oor = (rgp_pkg::CNT_W'(pixel_index) >= cnt_eff);
    data_nxt.quo = '0;
    for (int c = 0; c < rgp_pkg::NUM_CH; c++) begin
      delta[c] = {1'b0, to_ch[c]} - {1'b0, from_ch[c]};
      data_nxt.neg[c] = delta[c][rgp_pkg::CH_W];
      mag[c] = delta[c][rgp_pkg::CH_W] ? rgp_pkg::CH_W'(-delta[c])
                                       : delta[c][rgp_pkg::CH_W-1:0];
      data_nxt.rem[c] = rgp_pkg::REM_W'(pixel_index) * rgp_pkg::REM_W'(mag[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
`default_nettype wire

### rtl/rgp_div_cell.sv
// One cell of the restoring division chain: settles one quotient bit for all
// three channels and passes the item on. Depends on rgp_pkg.
`default_nettype none
module rgp_div_cell #(
  parameter int SHIFT = 0
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire rgp_pkg::div_data_t in_data,
  output logic                    out_valid,
  output rgp_pkg::div_data_t      out_data
);

  logic                           valid_r;
  rgp_pkg::div_data_t             data_r, data_nxt;
  logic [rgp_pkg::REM_W:0]        trial;

  assign trial = (rgp_pkg::REM_W + 1)'(in_data.cnt) << SHIFT;

  always_comb begin
    data_nxt = in_data;
    for (int c = 0; c < rgp_pkg::NUM_CH; c++) begin
      if ({1'b0, in_data.rem[c]} >= trial) begin
        data_nxt.rem[c]        = in_data.rem[c] - trial[rgp_pkg::REM_W-1:0];
        data_nxt.quo[c][SHIFT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
`default_nettype wire

### sim/tb_rgb565_gradient_pixel.sv
// Self-checking testbench for the RGB565 gradient pixel block.
// Programs the colour registers over APB and streams pixel indices through it.
// Depends on rtl/rgp_pkg.sv and rtl/rgb565_gradient_pixel.sv.
module tb_rgb565_gradient_pixel;
  import rgp_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int HOLD_CYCLES    = 300;
  localparam int NUM_REGS       = 7;
  localparam int REG_BEYOND_MAP = 7;
  localparam int MAX_LOGGED     = 100;

  // Keeps its own copy of the colour registers and a queue of pixels
  // still owed by the block.
  class gradient_scoreboard;
    typedef struct {
      logic [9:0] idx;
      logic [7:0] hi;
      logic [7:0] lo;
      logic       oor;
    } pixel_t;

    pixel_t           owed_q[$];
    logic [RB_W-1:0]  start_red, start_blue, end_red, end_blue;
    logic [CH_W-1:0]  start_green, end_green;
    logic [CNT_W-1:0] pixel_count;
    int               errors;

    function new();
      errors = 0;
      start_red   = '0;
      start_green = '0;
      start_blue  = '0;
      end_red     = '1;
      end_green   = '1;
      end_blue    = '1;
      pixel_count = MAX_PIXELS;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_LOGGED) $display("mismatch: %s", msg);
    endtask

    function void write_reg(int regno, logic [31:0] v);
      case (regno)
        int'(REG_START_RED):   start_red   = v[RB_W-1:0];
        int'(REG_START_GREEN): start_green = v[CH_W-1:0];
        int'(REG_START_BLUE):  start_blue  = v[RB_W-1:0];
        int'(REG_END_RED):     end_red     = v[RB_W-1:0];
        int'(REG_END_GREEN):   end_green   = v[CH_W-1:0];
        int'(REG_END_BLUE):    end_blue    = v[RB_W-1:0];
        int'(REG_PIXEL_COUNT): pixel_count = v[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(int regno);
      case (regno)
        int'(REG_START_RED):   return 32'(start_red);
        int'(REG_START_GREEN): return 32'(start_green);
        int'(REG_START_BLUE):  return 32'(start_blue);
        int'(REG_END_RED):     return 32'(end_red);
        int'(REG_END_GREEN):   return 32'(end_green);
        int'(REG_END_BLUE):    return 32'(end_blue);
        int'(REG_PIXEL_COUNT): return 32'(pixel_count);
        default:               return '0;
      endcase
    endfunction

    function int effective_count();
      return (pixel_count > MAX_PIXELS) ? int'(MAX_PIXELS) : int'(pixel_count);
    endfunction

    // Signed division of int operands truncates toward zero, which is what
    // a falling channel needs.
    function int blend(int from, int to, int idx, int cnt);
      return from + (idx * (to - from)) / cnt;
    endfunction

    function pixel_t gradient_pixel(logic [9:0] idx);
      pixel_t          p;
      int              cnt;
      logic [RB_W-1:0] r, b;
      logic [CH_W-1:0] g;
      cnt   = effective_count();
      p.idx = idx;
      p.hi  = '0;
      p.lo  = '0;
      p.oor = 1'b1;
      if (int'(idx) < cnt) begin
        r     = RB_W'(blend(start_red, end_red, idx, cnt));
        g     = CH_W'(blend(start_green, end_green, idx, cnt));
        b     = RB_W'(blend(start_blue, end_blue, idx, cnt));
        p.hi  = {r, g[5:3]};
        p.lo  = {g[2:0], b};
        p.oor = 1'b0;
      end
      return p;
    endfunction

    function void note_index(logic [9:0] idx);
      owed_q.push_back(gradient_pixel(idx));
    endfunction

    function int owed();
      return owed_q.size();
    endfunction

    task check_pixel(logic [15:0] data, logic oor);
      pixel_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("pixel %h oor %b with none owed", data, oor));
        return;
      end
      want = owed_q.pop_front();
      if (data[7:0] !== want.hi)
        report($sformatf("index %0d high byte %h, want %h", want.idx, data[7:0], want.hi));
      if (data[15:8] !== want.lo)
        report($sformatf("index %0d low byte %h, want %h", want.idx, data[15:8], want.lo));
      if (oor !== want.oor)
        report($sformatf("index %0d out-of-range %b, want %b", want.idx, oor, want.oor));
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic [15:0]       in_tdata;
  logic              in_tvalid;
  logic              in_tready;
  logic [15:0]       out_tdata;
  logic              out_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [DATA_W-1:0] cfg_pwdata;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  gradient_scoreboard sb;
  int cycle_count     = 0;
  bit index_gaps      = 1'b0;
  bit result_stalls   = 1'b0;
  bit hold_request    = 1'b0;

  rgb565_gradient_pixel dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_rgb565_gradient_pixel: errors");
      $finish;
    end
  end

  task automatic apb_write(input int regno, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'(regno * 4);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    sb.write_reg(regno, value);
    @(posedge clk);
  endtask

  task automatic apb_read(input int regno, output logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= ADDR_W'(regno * 4);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    value = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_registers();
    logic [31:0] value;
    for (int i = 0; i < NUM_REGS; i++) begin
      apb_read(i, value);
      if (value !== sb.reg_value(i))
        sb.report($sformatf("register %0d reads %h, want %h", i, value, sb.reg_value(i)));
    end
  endtask

  // in_tvalid is lowered only when a gap follows, so back-to-back transfers
  // never see it dropped and raised within one step.
  task automatic send_index(input logic [9:0] idx);
    int gap;
    gap = index_gaps ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, idx};
    do @(posedge clk); while (!in_tready);
    sb.note_index(idx);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.owed() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [9:0] pick_index();
    int cnt;
    int pick;
    cnt  = sb.effective_count();
    pick = $urandom_range(0, 15);
    if (cnt == 0 || pick < 2) return 10'($urandom_range(0, 1023));
    if (pick == 2) return 10'(cnt - 1);
    if (pick == 3 && cnt < 1024) return 10'(cnt);
    return 10'($urandom_range(0, cnt - 1));
  endfunction

  function automatic logic [31:0] random_channel();
    logic [31:0] v;
    int          pick;
    v    = $urandom();
    pick = $urandom_range(0, 3);
    if (pick == 0) v[CH_W-1:0] = '0;
    else if (pick == 1) v[CH_W-1:0] = '1;
    return v;
  endfunction

  task automatic random_config();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(0, 4))
      0: v[CNT_W-1:0] = CNT_W'($urandom_range(1, 16));
      1: v[CNT_W-1:0] = MAX_PIXELS;
      2: v[CNT_W-1:0] = CNT_W'($urandom_range(1, 1024));
      default: ;
    endcase
    apb_write(REG_START_RED, random_channel());
    apb_write(REG_START_GREEN, random_channel());
    apb_write(REG_START_BLUE, random_channel());
    apb_write(REG_END_RED, random_channel());
    apb_write(REG_END_GREEN, random_channel());
    apb_write(REG_END_BLUE, random_channel());
    apb_write(REG_PIXEL_COUNT, v);
    if ($urandom_range(0, 3) == 0) apb_write(REG_BEYOND_MAP, $urandom());
  endtask

  task automatic run_phase(input int n, input bit drain_midway);
    for (int k = 0; k < n; k++) begin
      if (drain_midway && k == n / 2) drain();
      send_index(pick_index());
    end
    drain();
  endtask

  // Result side: a random stall before each transfer, or one long hold-off
  // when asked, during which the block backs up and stops taking indices.
  initial begin
    int stall;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = result_stalls ? $urandom_range(0, 6) : 0;
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_pixel(out_tdata, out_tuser);
    end
  end

  initial begin
    sb = new();
    rst_n       <= 1'b0;
    in_tdata    <= '0;
    in_tvalid   <= 1'b0;
    out_tready  <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset colours: black to white over the full 1024 pixels.
    check_registers();
    index_gaps    = 1'b1;
    result_stalls = 1'b1;
    send_index(10'd0);
    send_index(10'd1023);
    send_index(10'd512);
    send_index(10'd1);
    send_index(10'h2AA);
    send_index(10'h155);
    drain();

    // A single pixel: only index zero is inside the gradient.
    apb_write(REG_PIXEL_COUNT, 32'hFFFF_F801);
    check_registers();
    send_index(10'd0);
    send_index(10'd1);
    send_index(10'd1023);
    drain();

    // A count of zero puts every index out of range.
    apb_write(REG_PIXEL_COUNT, 32'hFFFF_F800);
    send_index(10'd0);
    send_index(10'd1023);
    drain();

    // Falling channels with oversized values, and a count that saturates.
    apb_write(REG_START_RED, 32'hFFFF_FFFF);
    apb_write(REG_START_GREEN, 32'hFFFF_FFFF);
    apb_write(REG_START_BLUE, 32'hFFFF_FFFF);
    apb_write(REG_END_RED, 32'hFFFF_FFE0);
    apb_write(REG_END_GREEN, 32'hFFFF_FFC0);
    apb_write(REG_END_BLUE, 32'hFFFF_FFE0);
    apb_write(REG_PIXEL_COUNT, 32'h0000_07FF);
    apb_write(REG_BEYOND_MAP, 32'hFFFF_FFFF);
    check_registers();
    send_index(10'd0);
    send_index(10'd1023);
    send_index(10'd1022);
    send_index(10'd511);
    drain();

    // Just above the maximum count, and a colour that falls on every channel.
    apb_write(REG_START_RED, 32'd3);
    apb_write(REG_END_GREEN, 32'd40);
    apb_write(REG_END_BLUE, 32'd17);
    apb_write(REG_PIXEL_COUNT, 32'hABCD_F401);
    check_registers();
    send_index(10'd1023);
    send_index(10'd700);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      random_config();
      check_registers();
      index_gaps    = (ph % 3 != 0);
      result_stalls = (ph % 4 != 1);
      if (ph == 3) begin
        index_gaps   = 1'b0;
        hold_request = 1'b1;
      end
      run_phase(244, ph == 5);
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_rgb565_gradient_pixel: clean");
    end else begin
      $display("tb_rgb565_gradient_pixel: errors");
    end
    $finish;
  end

endmodule

### sim.f
rtl/rgp_pkg.sv
rtl/rgp_cfg_regs.sv
rtl/rgp_front.sv
rtl/rgp_div_cell.sv
rtl/rgb565_gradient_pixel.sv
sim/tb_rgb565_gradient_pixel.sv
